>>> rtl/swr_pkg.sv
// ----------------------------------------------------------------------------
// swr_pkg
// Shared types and constants for the skin weight reduce block.
// ----------------------------------------------------------------------------
`default_nettype none

package swr_pkg;

  localparam int unsigned JOINT_W    = 8;
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned MAXK_W     = 4;
  localparam int unsigned MINF_W     = 16;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // at most this many results per vertex
  localparam int unsigned RESULT_LIMIT = 8;
  localparam int unsigned KEPT_W       = $clog2(RESULT_LIMIT + 1);
  localparam int unsigned SUM_W        = WEIGHT_W + $clog2(RESULT_LIMIT);

  // Q1.16 quotient and its dividend (weight << 16 plus half the sum)
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned QUOT_W = FRAC_W + 1;
  localparam int unsigned NUM_W  = WEIGHT_W + FRAC_W + 1;
  localparam int unsigned DCNT_W = $clog2(QUOT_W + 1);

  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 32;
  localparam int unsigned M_TUSER_W = 2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_REDUCE_MODE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_KEPT      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_INFLUENCE = 2'd2;

  // one stored influence
  typedef struct packed {
    logic [JOINT_W-1:0]  joint;
    logic [WEIGHT_W-1:0] weight;
  } swr_entry_t;

  // per-cycle command to the cell chain
  typedef struct packed {
    logic insert;
    logic rotate;
  } swr_cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SUM,
    ST_START,
    ST_DIV,
    ST_OUT
  } swr_state_e;

endpackage : swr_pkg

`default_nettype wire

>>> rtl/swr_cell.sv
// ----------------------------------------------------------------------------
// swr_cell
// One slot of the sorted influence chain: sorted insert and rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module swr_cell
  import swr_pkg::*;
(
  input  wire logic           clk_i,
  input  wire swr_cell_ctrl_t ctrl_i,
  input  wire logic           valid_i,   // slot holds a stored influence
  input  wire logic           wrap_i,    // slot is the last occupied one
  input  wire swr_entry_t     new_i,     // incoming influence
  input  wire swr_entry_t     head_i,    // content of slot zero
  input  wire swr_entry_t     prev_i,    // neighbor toward the head
  input  wire logic           prev_keep_i,
  input  wire swr_entry_t     next_i,    // neighbor toward the tail
  output swr_entry_t          entry_o,
  output logic                keep_o
);

  swr_entry_t entry_q, entry_d;

  // equal weights stay ahead of the newcomer, which keeps input order
  assign keep_o  = valid_i && (entry_q.weight >= new_i.weight);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (!keep_o) begin
        entry_d = prev_keep_i ? new_i : prev_i;
      end
    end else if (ctrl_i.rotate) begin
      entry_d = wrap_i ? head_i : next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule : swr_cell

`default_nettype wire

>>> rtl/swr_div.sv
// ----------------------------------------------------------------------------
// swr_div
// Restoring divider, one quotient bit per cycle, for Q1.16 normalization.
// ----------------------------------------------------------------------------
`default_nettype none

module swr_div
  import swr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [SUM_W-1:0]  den_i,
  output logic                   done_o,
  output logic [QUOT_W-1:0]      quot_o
);

  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  den_q, den_d;
  logic [QUOT_W-1:0] shf_q, shf_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [SUM_W:0]    trial;
  logic              fits;

  // shift in next dividend bit, compare against divisor
  assign trial  = {rem_q, shf_q[QUOT_W-1]};
  assign fits   = trial >= {1'b0, den_q};
  assign done_o = done_q;
  assign quot_o = shf_q;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    shf_d  = shf_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // top bits start below the divisor since the quotient fits QUOT_W
      rem_d  = SUM_W'(num_i[NUM_W-1:QUOT_W]);
      shf_d  = num_i[QUOT_W-1:0];
      den_d  = den_i;
      cnt_d  = DCNT_W'(QUOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? SUM_W'(trial - {1'b0, den_q}) : trial[SUM_W-1:0];
      shf_d  = {shf_q[QUOT_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    shf_q <= shf_d;
  end

endmodule : swr_div

`default_nettype wire

>>> rtl/skin_weight_reduce_core.sv
// Flow: influences load one per cycle during the load phase; a last item
// starts a sum pass over the stored influences, then each kept entry goes
// through divider start, one divider step per quotient bit, done seen and
// present, plus output stall. Results come one at a time from the divider.
// Reset (rst_ni low, asynchronous) empties the store and restores registers
// to count mode, max_kept 4, min_influence 0.
// ----------------------------------------------------------------------------
// skin_weight_reduce_core
// Sorts a vertex's joint influences in a cell chain, keeps the top ones and
// normalizes them to Q1.16.
// ----------------------------------------------------------------------------
`default_nettype none

module skin_weight_reduce_core
  import swr_pkg::*;
#(
  parameter int unsigned MaxWeights = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  // influence input
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]   s_axis_tdata,  // joint_index, raw_weight
  input  wire logic                   s_axis_tlast,
  // result output
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [M_TDATA_W-1:0]        m_axis_tdata,  // out_joint, norm_weight, pad
  output logic [M_TUSER_W-1:0]        m_axis_tuser,  // first_entry, dropped_input
  output logic                        m_axis_tlast
);

  localparam int unsigned CNT_W = $clog2(MaxWeights + 1);

  swr_state_e state_q, state_d;

  // configuration registers
  logic                reduce_mode_q;
  logic [MAXK_W-1:0]   max_kept_q;
  logic [MINF_W-1:0]   min_influence_q;

  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    step_q, step_d;
  logic [CNT_W-1:0]    count_last;
  logic                ovf_q, ovf_d;
  logic                cut_q, cut_d;
  logic [KEPT_W-1:0]   kept_q, kept_d;
  logic [KEPT_W-1:0]   ent_q, ent_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [QUOT_W-1:0]   norm_q, norm_d;

  swr_cell_ctrl_t      cell_ctrl;
  swr_entry_t          new_entry;
  swr_entry_t          head;
  swr_entry_t          entry     [MaxWeights];
  swr_entry_t          prev_ent  [MaxWeights];
  swr_entry_t          next_ent  [MaxWeights];
  logic                keep      [MaxWeights];
  logic                prev_keep [MaxWeights];

  logic [MAXK_W-1:0]   lim_raw;
  logic [KEPT_W-1:0]   lim_eff;
  logic                cut_now;
  logic                take;
  logic                div_start;
  logic                div_done;
  logic [QUOT_W-1:0]   div_quot;
  logic [NUM_W-1:0]    div_num;

  assign new_entry.joint  = s_axis_tdata[JOINT_W-1:0];
  assign new_entry.weight = s_axis_tdata[JOINT_W +: WEIGHT_W];
  assign head             = entry[0];
  assign count_last       = count_q - 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reduce_mode_q   <= 1'b0;
      max_kept_q      <= MAXK_W'(4);
      min_influence_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_REDUCE_MODE:   reduce_mode_q   <= cfg_data_i[0];
        CFG_MAX_KEPT:      max_kept_q      <= cfg_data_i[MAXK_W-1:0];
        CFG_MIN_INFLUENCE: min_influence_q <= cfg_data_i[MINF_W-1:0];
        default: ;
      endcase
    end
  end

  // sorted cell chain
  for (genvar g = 0; g < MaxWeights; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_ent[g]  = new_entry;
      assign prev_keep[g] = 1'b1;
    end else begin : g_body
      assign prev_ent[g]  = entry[g-1];
      assign prev_keep[g] = keep[g-1];
    end
    if (g == MaxWeights - 1) begin : g_tail
      assign next_ent[g] = entry[g];
    end else begin : g_mid
      assign next_ent[g] = entry[g+1];
    end

    swr_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .valid_i     (CNT_W'(g) < count_q),
      .wrap_i      (CNT_W'(g) == count_last),
      .new_i       (new_entry),
      .head_i      (head),
      .prev_i      (prev_ent[g]),
      .prev_keep_i (prev_keep[g]),
      .next_i      (next_ent[g]),
      .entry_o     (entry[g]),
      .keep_o      (keep[g])
    );
  end

  // kept-entry limit and threshold cut for the sum pass
  assign lim_raw = (max_kept_q == '0) ? MAXK_W'(1) : max_kept_q;
  always_comb begin
    if (reduce_mode_q) begin
      lim_eff = KEPT_W'(RESULT_LIMIT);
    end else if (KEPT_W'(lim_raw) > KEPT_W'(RESULT_LIMIT)) begin
      lim_eff = KEPT_W'(RESULT_LIMIT);
    end else begin
      lim_eff = KEPT_W'(lim_raw);
    end
  end
  assign cut_now = cut_q || (reduce_mode_q && (step_q != '0) &&
                             (head.weight < min_influence_q));
  assign take    = (kept_q < lim_eff) && !cut_now;

  // divider, one kept entry at a time
  assign div_num = NUM_W'({head.weight, FRAC_W'(0)}) + NUM_W'(sum_q >> 1);

  swr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (sum_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // sequencer
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    step_d        = step_q;
    ovf_d         = ovf_q;
    cut_d         = cut_q;
    kept_d        = kept_q;
    ent_d         = ent_q;
    sum_d         = sum_q;
    norm_d        = norm_q;
    cell_ctrl     = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    div_start     = 1'b0;
    case (state_q)
      ST_LOAD: begin
        // ready stays high for the whole load phase
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (count_q < CNT_W'(MaxWeights)) begin
            cell_ctrl.insert = 1'b1;
            count_d          = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            step_d  = '0;
            cut_d   = 1'b0;
            kept_d  = '0;
            sum_d   = '0;
            state_d = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        // walk the chain once, summing the kept prefix
        cell_ctrl.rotate = 1'b1;
        cut_d            = cut_now;
        step_d           = step_q + 1'b1;
        if (take) begin
          sum_d  = sum_q + SUM_W'(head.weight);
          kept_d = kept_q + 1'b1;
        end
        if (step_q == count_last) begin
          ent_d   = '0;
          state_d = ST_START;
        end
      end
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          norm_d  = (sum_q == '0) ? '0 : div_quot;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          cell_ctrl.rotate = 1'b1;
          ent_d            = ent_q + 1'b1;
          if (m_axis_tlast) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            state_d = ST_START;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      step_q  <= '0;
      ovf_q   <= 1'b0;
      cut_q   <= 1'b0;
      kept_q  <= '0;
      ent_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      ovf_q   <= ovf_d;
      cut_q   <= cut_d;
      kept_q  <= kept_d;
      ent_q   <= ent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    norm_q <= norm_d;
  end

  // result fields
  assign m_axis_tdata = {(M_TDATA_W - QUOT_W - JOINT_W)'(0), norm_q, head.joint};
  assign m_axis_tuser = {ovf_q, ent_q == '0};
  assign m_axis_tlast = (ent_q == kept_q - 1'b1);

endmodule : skin_weight_reduce_core

`default_nettype wire

>>> rtl/swr_checker.sv
// ----------------------------------------------------------------------------
// swr_checker
// Port-level checks for skin_weight_reduce_core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swr_checker
  import swr_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  s_axis_tlast,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [M_TDATA_W-1:0]  m_axis_tdata,
  input wire logic                  m_axis_tlast
);

  // a pending result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while results pending");

  // the last influence closes the input until results are out
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input reopened after last influence");

  // the final result returns the block to loading
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
    else $error("results continue past the final one");

  // a normalized weight never exceeds one
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[JOINT_W +: QUOT_W] <= QUOT_W'(65536))
    else $error("normalized weight above one");

endmodule : swr_checker

bind skin_weight_reduce_core swr_checker u_swr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
